/* src/cts_pkg.sv */
// shared constants, tables and payload types for the cartesian to spherical converter
package cts_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 24;
  localparam int FRAC_BITS     = 8;
  // scaled coordinate plus headroom for negation, sqrt(3) spread and cordic gain
  localparam int DATA_WIDTH    = COORD_WIDTH + FRAC_BITS + 3;
  localparam int ACC_WIDTH     = 32;
  localparam int INVK_WIDTH    = 30;

  // 1/K in q30, base value and a small tail that only matters for short chains
  localparam logic [63:0] INVK_BASE = 64'd652032874;
  localparam logic [63:0] INVK_CORR = 64'd434688583;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [ACC_WIDTH-1:0] ATAN_TURNS [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_position;
    logic signed [COORD_WIDTH-1:0] y_position;
    logic signed [COORD_WIDTH-1:0] z_position;
  } position_t;

  typedef struct packed {
    logic        [COORD_WIDTH-1:0] target_range;
    logic signed [ANGLE_WIDTH-1:0] azimuth;
    logic signed [ANGLE_WIDTH-1:0] elevation;
  } measurement_t;

endpackage

/* src/cts_cordic_cell.sv */
// one vectoring cordic micro-rotation with a fixed shift, registered
module cts_cordic_cell #(
  parameter int W     = cts_pkg::DATA_WIDTH,
  parameter int STAGE = 0,
  parameter int SB_W  = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [W-1:0]            x_i,
  input  logic signed [W-1:0]            y_i,
  input  logic [cts_pkg::ACC_WIDTH-1:0]  acc_i,
  input  logic [SB_W-1:0]                sb_i,
  output logic                           valid_o,
  output logic signed [W-1:0]            x_o,
  output logic signed [W-1:0]            y_o,
  output logic [cts_pkg::ACC_WIDTH-1:0]  acc_o,
  output logic [SB_W-1:0]                sb_o
);

  localparam logic [cts_pkg::ACC_WIDTH-1:0] ANGLE_STEP = cts_pkg::ATAN_TURNS[STAGE];

  logic signed [W-1:0]           xs, ys;
  logic signed [W-1:0]           x_d, y_d;
  logic [cts_pkg::ACC_WIDTH-1:0] acc_d;
  logic                          valid_q;
  logic signed [W-1:0]           x_q, y_q;
  logic [cts_pkg::ACC_WIDTH-1:0] acc_q;
  logic [SB_W-1:0]               sb_q;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  // rotate toward y = 0
  always_comb begin
    if (!y_i[W-1]) begin
      x_d   = x_i + ys;
      y_d   = y_i - xs;
      acc_d = acc_i + ANGLE_STEP;
    end else begin
      x_d   = x_i - ys;
      y_d   = y_i + xs;
      acc_d = acc_i - ANGLE_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    sb_q  <= sb_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign acc_o   = acc_q;
  assign sb_o    = sb_q;

endmodule

/* src/cts_gain_comp.sv */
// two-stage cordic gain compensation, multiply by 1/K in q30 with rounding
module cts_gain_comp #(
  parameter int                                W    = cts_pkg::DATA_WIDTH,
  parameter int                                SB_W = 1,
  parameter logic [cts_pkg::INVK_WIDTH-1:0]    INVK = cts_pkg::INVK_BASE[cts_pkg::INVK_WIDTH-1:0]
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [W-1:0]    a_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            valid_o,
  output logic [W-1:0]    p_o,
  output logic [SB_W-1:0] sb_o
);

  localparam int KW    = cts_pkg::INVK_WIDTH;
  localparam int HI_W  = W + KW - 15;
  localparam int LO_W  = 15 + KW;
  localparam int SUM_W = HI_W + 1;

  logic [HI_W-1:0]  hi_d, hi_q;
  logic [LO_W-1:0]  lo_d, lo_q;
  logic [SB_W-1:0]  sb1_q, sb2_q;
  logic             valid1_q, valid2_q;
  logic [SUM_W-1:0] sum;
  logic [W-1:0]     p_q;

  // split product keeps each multiplier narrow
  assign hi_d = HI_W'(a_i[W-1:15]) * HI_W'(INVK);
  assign lo_d = LO_W'(a_i[14:0]) * LO_W'(INVK);

  assign sum = SUM_W'(hi_q) + SUM_W'(lo_q[LO_W-1:15]) + SUM_W'(1 << 14);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    sb1_q <= sb_i;
    p_q   <= sum[W+14:15];
    sb2_q <= sb1_q;
  end

  assign valid_o = valid2_q;
  assign p_o     = p_q;
  assign sb_o    = sb2_q;

endmodule

/* src/cartesian_to_spherical_top.sv */
// cartesian to spherical converter: two pipelined cordic vectoring chains with gain compensation
//
// usage
// - input: pulse start with a position on pos_i; the transfer happens at any rising edge
//   where start is high and busy is low; busy is tied low, so a new position can be
//   given in every cycle
// - output: result_o carries slant range, azimuth and elevation for exactly one cycle,
//   marked by result_valid_o; the receiver takes it in that cycle and cannot stall
// - pipeline: the input register, one cell per cordic iteration in the azimuth chain, the
//   horizontal range gain multiplier, one cell per iteration in the elevation chain, the
//   slant range gain multiplier and the output register, in that order; throughput one
//   position per cycle
// - reset clears every valid bit in the pipeline, so positions in flight are dropped
//   and no result appears until a new start
// - results leave in the order that positions arrived, one per position
// - origin in the x-y plane gives azimuth zero; full origin gives all zeros
module cartesian_to_spherical_top #(
  parameter int CORDIC_STAGES = cts_pkg::CORDIC_STAGES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cts_pkg::position_t    pos_i,
  output logic                  result_valid_o,
  output cts_pkg::measurement_t result_o
);

  localparam int CW   = cts_pkg::COORD_WIDTH;
  localparam int AW   = cts_pkg::ANGLE_WIDTH;
  localparam int FRAC = cts_pkg::FRAC_BITS;
  localparam int W    = cts_pkg::DATA_WIDTH;
  localparam int AC   = cts_pkg::ACC_WIDTH;
  localparam int SH   = AC - AW;
  localparam int N    = CORDIC_STAGES;
  localparam int LATENCY = 2 * N + 6;

  // 1/K for this chain length
  localparam logic [63:0] INVK_FULL =
    cts_pkg::INVK_BASE + (cts_pkg::INVK_CORR >> (2 * N));
  localparam logic [cts_pkg::INVK_WIDTH-1:0] INVK = INVK_FULL[cts_pkg::INVK_WIDTH-1:0];

  localparam int AZ_SB_W = CW + 1;   // z coordinate and plane-origin flag
  localparam int G1_SB_W = CW + AC;  // z coordinate and azimuth turn
  localparam int EL_SB_W = AC + 1;   // azimuth turn and origin flag
  localparam int G2_SB_W = 2 * AC;   // azimuth and elevation turns

  // input is never held off
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // input register: scale to fixed point, fold the left half plane
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] x_in, y_in;
  logic                plane_zero;
  logic                in_valid_q;
  logic signed [W-1:0] in_x_q, in_y_q;
  logic [AC-1:0]       in_acc_q;
  logic [AZ_SB_W-1:0]  in_sb_q;

  assign x_in = {{(W-CW-FRAC){pos_i.x_position[CW-1]}}, pos_i.x_position, {FRAC{1'b0}}};
  assign y_in = {{(W-CW-FRAC){pos_i.y_position[CW-1]}}, pos_i.y_position, {FRAC{1'b0}}};
  assign plane_zero = (pos_i.x_position == '0) && (pos_i.y_position == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    // negative x: rotate by a half turn first
    if (x_in[W-1]) begin
      in_x_q   <= -x_in;
      in_y_q   <= -y_in;
      in_acc_q <= AC'(1) << (AC - 1);
    end else begin
      in_x_q   <= x_in;
      in_y_q   <= y_in;
      in_acc_q <= '0;
    end
    in_sb_q <= {plane_zero, pos_i.z_position};
  end

  // ---------------------------------------------------------------------------
  // azimuth chain on (x, y)
  // ---------------------------------------------------------------------------
  logic                az_valid [N+1];
  logic signed [W-1:0] az_x     [N+1];
  logic signed [W-1:0] az_y     [N+1];
  logic [AC-1:0]       az_acc   [N+1];
  logic [AZ_SB_W-1:0]  az_sb    [N+1];

  assign az_valid[0] = in_valid_q;
  assign az_x[0]     = in_x_q;
  assign az_y[0]     = in_y_q;
  assign az_acc[0]   = in_acc_q;
  assign az_sb[0]    = in_sb_q;

  for (genvar i = 0; i < N; i++) begin : g_az
    cts_cordic_cell #(
      .W     (W),
      .STAGE (i),
      .SB_W  (AZ_SB_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (az_valid[i]),
      .x_i     (az_x[i]),
      .y_i     (az_y[i]),
      .acc_i   (az_acc[i]),
      .sb_i    (az_sb[i]),
      .valid_o (az_valid[i+1]),
      .x_o     (az_x[i+1]),
      .y_o     (az_y[i+1]),
      .acc_o   (az_acc[i+1]),
      .sb_o    (az_sb[i+1])
    );
  end

  logic [AC-1:0]      az_turn;
  logic [W-1:0]       hr_raw;
  logic [CW-1:0]      az_z;

  // plane origin forces azimuth to zero; negative magnitude clamps to zero
  assign az_turn = az_sb[N][CW] ? '0 : az_acc[N];
  assign hr_raw  = az_x[N][W-1] ? '0 : az_x[N];
  assign az_z    = az_sb[N][CW-1:0];

  // ---------------------------------------------------------------------------
  // horizontal range gain compensation
  // ---------------------------------------------------------------------------
  logic               g1_valid;
  logic [W-1:0]       hr;
  logic [G1_SB_W-1:0] g1_sb;

  cts_gain_comp #(
    .W    (W),
    .SB_W (G1_SB_W),
    .INVK (INVK)
  ) u_gain_hr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (az_valid[N]),
    .a_i     (hr_raw),
    .sb_i    ({az_z, az_turn}),
    .valid_o (g1_valid),
    .p_o     (hr),
    .sb_o    (g1_sb)
  );

  // ---------------------------------------------------------------------------
  // elevation chain on (horizontal range, z)
  // ---------------------------------------------------------------------------
  logic [CW-1:0]       g1_z;
  logic [AC-1:0]       g1_az;
  logic                full_zero;

  assign g1_z      = g1_sb[G1_SB_W-1:AC];
  assign g1_az     = g1_sb[AC-1:0];
  assign full_zero = (hr == '0) && (g1_z == '0);

  logic                el_valid [N+1];
  logic signed [W-1:0] el_x     [N+1];
  logic signed [W-1:0] el_y     [N+1];
  logic [AC-1:0]       el_acc   [N+1];
  logic [EL_SB_W-1:0]  el_sb    [N+1];

  assign el_valid[0] = g1_valid;
  assign el_x[0]     = hr;
  assign el_y[0]     = {{(W-CW-FRAC){g1_z[CW-1]}}, g1_z, {FRAC{1'b0}}};
  assign el_acc[0]   = '0;
  assign el_sb[0]    = {full_zero, g1_az};

  for (genvar i = 0; i < N; i++) begin : g_el
    cts_cordic_cell #(
      .W     (W),
      .STAGE (i),
      .SB_W  (EL_SB_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (el_valid[i]),
      .x_i     (el_x[i]),
      .y_i     (el_y[i]),
      .acc_i   (el_acc[i]),
      .sb_i    (el_sb[i]),
      .valid_o (el_valid[i+1]),
      .x_o     (el_x[i+1]),
      .y_o     (el_y[i+1]),
      .acc_o   (el_acc[i+1]),
      .sb_o    (el_sb[i+1])
    );
  end

  logic [AC-1:0] el_turn;
  logic [W-1:0]  sr_raw;

  // full origin: elevation zero; range is zero already since the magnitude is
  assign el_turn = el_sb[N][AC] ? '0 : el_acc[N];
  assign sr_raw  = el_x[N][W-1] ? '0 : el_x[N];

  // ---------------------------------------------------------------------------
  // slant range gain compensation
  // ---------------------------------------------------------------------------
  logic               g2_valid;
  logic [W-1:0]       sr;
  logic [G2_SB_W-1:0] g2_sb;

  cts_gain_comp #(
    .W    (W),
    .SB_W (G2_SB_W),
    .INVK (INVK)
  ) u_gain_sr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (el_valid[N]),
    .a_i     (sr_raw),
    .sb_i    ({el_sb[N][AC-1:0], el_turn}),
    .valid_o (g2_valid),
    .p_o     (sr),
    .sb_o    (g2_sb)
  );

  // ---------------------------------------------------------------------------
  // output register: drop fraction bits with rounding, round angles
  // ---------------------------------------------------------------------------
  logic [W:0]         rng_sum;
  logic [W-FRAC:0]    rng_full;
  logic [CW-1:0]      rng;
  logic [AC-1:0]      az_round, el_round;
  logic               out_valid_q;
  cts_pkg::measurement_t out_q;

  assign rng_sum  = (W+1)'(sr) + (W+1)'(1 << (FRAC - 1));
  assign rng_full = rng_sum[W:FRAC];
  // saturate, only reachable with out-of-range magnitudes
  assign rng      = (|rng_full[W-FRAC:CW]) ? '1 : rng_full[CW-1:0];

  assign az_round = g2_sb[G2_SB_W-1:AC] + (AC'(1) << (SH - 1));
  assign el_round = g2_sb[AC-1:0] + (AC'(1) << (SH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= g2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.target_range <= rng;
    out_q.azimuth      <= az_round[AC-1:SH];
    out_q.elevation    <= el_round[AC-1:SH];
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY result_valid_o)
    else $error("start transfer without result after pipeline latency");

  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, LATENCY))
    else $error("result without matching start transfer");

  a_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && pos_i == '0) |-> ##LATENCY (result_o == '0))
    else $error("origin did not give an all-zero result");

endmodule
